FILE: hdl/fractal_value_noise_2d_core_macros.svh
// ----------------------------------------------------------------------------
// Fractal value noise core assertion macros
// Concurrent checks that are dropped in synthesis.
// ----------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_2D_CORE_MACROS_SVH
`define FRACTAL_VALUE_NOISE_2D_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define FVN_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FVN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FVN_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define FVN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/fvn_pkg.sv
// ----------------------------------------------------------------------------
// Fractal value noise package
// Shared constants and the types handed between octave cells.
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int GRID_LOG    = 6;
    localparam int TABLE_AW    = 2 * GRID_LOG;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;
    localparam int MAX_OCTAVES = 8;
    localparam int PT_W        = 24 + GRID_LOG;
    localparam int TOTAL_W     = 44;
    localparam int AMP_W       = 17;

    localparam logic [1:0] REG_OCTAVES = 2'd0;
    localparam logic [1:0] REG_PERSIST = 2'd1;
    localparam logic [1:0] REG_BASE    = 2'd2;
    localparam logic [1:0] REG_NORM    = 2'd3;

    typedef struct packed {
        logic [PT_W-1:0]    px;
        logic [PT_W-1:0]    py;
        logic [AMP_W-1:0]   amp;
        logic [TOTAL_W-1:0] total;
    } t_oct;

    typedef struct packed {
        logic valid;
        t_oct data;
    } t_tok;

    typedef struct packed {
        logic [TABLE_AW-1:0] addr_a;
        logic [TABLE_AW-1:0] addr_b;
    } t_req;

endpackage

FILE: hdl/fvn_in_if.sv
// ----------------------------------------------------------------------------
// Fractal value noise input channel
// Valid/ready channel carrying one load or query transaction.
// ----------------------------------------------------------------------------
interface fvn_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [11:0]        table_index;
    logic [7:0]         table_value;

    modport source (output valid, mode, coord_x, coord_y, table_index, table_value,
                    input ready);
    modport sink (input valid, mode, coord_x, coord_y, table_index, table_value,
                  output ready);
endinterface

FILE: hdl/fvn_out_if.sv
// ----------------------------------------------------------------------------
// Fractal value noise output channel
// Valid/ready channel carrying one noise height transaction.
// ----------------------------------------------------------------------------
interface fvn_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] noise_height;

    modport source (output valid, noise_height, input ready);
    modport sink (input valid, noise_height, output ready);
endinterface

FILE: hdl/fractal_value_noise_2d_core.sv
// ----------------------------------------------------------------------------
// Fractal value noise core
// 64x64 table of 8-bit values; queries sum up to eight octaves of smoothed
// bilinear value noise and scale the sum by a normalizing gain.
//
//   channel   dir  handshake     payload
//   i_item    in   valid/ready   mode, coord_x, coord_y, table_index, table_value
//   o_result  out  valid/ready   noise_height
//   i_cfg_*   in   write enable  index, data
//
// A load writes the table as it is accepted. A query passes the start
// register, the chain of octave cells sharing the two table read ports, the
// normalizing multiply and the hold and output registers. Reset clears
// control; the table is undefined until loaded. A finished result waits in
// the output register while the next transaction is taken.
// ----------------------------------------------------------------------------
`include "fractal_value_noise_2d_core_macros.svh"

module fractal_value_noise_2d_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    fvn_in_if.sink      i_item,
    fvn_out_if.source   o_result
);
    import fvn_pkg::*;

    logic [3:0]  r_oct;
    logic [15:0] r_pers;
    logic [15:0] r_base;
    logic [16:0] r_norm;

    logic        r_busy;
    logic        r_start_v;
    t_oct        r_start;
    logic [7:0]  r_mem [TABLE_DEPTH];
    logic [7:0]  r_rd_a, r_rd_b;

    t_tok        w_tok [MAX_OCTAVES+1];
    t_req        w_req [MAX_OCTAVES];
    t_req        w_req_or;
    logic [MAX_OCTAVES-1:0] w_en, w_cb;
    logic [3:0]  w_oct;
    logic        w_acc;
    logic [47:0] w_mx, w_my;

    logic        r_n1_v;
    logic [38:0] r_plo, r_phi;
    logic [60:0] w_sum;
    logic        r_hold_v;
    logic [15:0] r_hold;
    logic        r_ov;
    logic [15:0] r_oh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct  <= 4'd4;
            r_pers <= 16'd32768;
            r_base <= 16'd256;
            r_norm <= 17'd34953;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_OCTAVES: r_oct  <= i_cfg_data[3:0];
                REG_PERSIST: r_pers <= i_cfg_data[15:0];
                REG_BASE:    r_base <= i_cfg_data[15:0];
                REG_NORM:    r_norm <= i_cfg_data;
                default:     r_oct  <= r_oct;
            endcase
        end
    end

    assign w_acc        = i_item.valid & i_item.ready;
    assign i_item.ready = !r_busy;
    assign w_mx = 48'(unsigned'(i_item.coord_x)) * 48'(r_base);
    assign w_my = 48'(unsigned'(i_item.coord_y)) * 48'(r_base);

    always_ff @(posedge i_clk) begin
        if (w_acc && !i_item.mode) begin
            r_mem[i_item.table_index] <= i_item.table_value;
        end
        r_rd_a <= r_mem[w_req_or.addr_a];
        r_rd_b <= r_mem[w_req_or.addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_v <= 1'b0;
        end else begin
            r_start_v <= w_acc & i_item.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_start.px    <= w_mx[PT_W-1:0];
            r_start.py    <= w_my[PT_W-1:0];
            r_start.amp   <= AMP_W'(17'h10000);
            r_start.total <= '0;
        end
    end

    assign w_oct = (r_oct > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : r_oct;

    assign w_tok[0].valid = r_start_v;
    assign w_tok[0].data  = r_start;

    always_comb begin
        w_req_or = '0;
        for (int k = 0; k < MAX_OCTAVES; k++) begin
            w_en[k]  = w_oct > 4'(k);
            w_req_or = w_req_or | w_req[k];
        end
    end

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
        fvn_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[g]),
            .i_pers  (r_pers),
            .i_tok   (w_tok[g]),
            .i_rd_a  (r_rd_a),
            .i_rd_b  (r_rd_b),
            .o_req   (w_req[g]),
            .o_tok   (w_tok[g+1]),
            .o_busy  (w_cb[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1_v <= 1'b0;
        end else begin
            r_n1_v <= w_tok[MAX_OCTAVES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[MAX_OCTAVES].valid) begin
            r_plo <= 39'(w_tok[MAX_OCTAVES].data.total[21:0]) * 39'(r_norm);
            r_phi <= 39'(w_tok[MAX_OCTAVES].data.total[43:22]) * 39'(r_norm);
        end
    end

    assign w_sum = {r_phi, 22'd0} + 61'(r_plo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (w_acc && i_item.mode) begin
                r_busy <= 1'b1;
            end
            if (r_n1_v) begin
                r_hold_v <= 1'b1;
            end
            if (r_hold_v && (!r_ov || o_result.ready)) begin
                r_ov     <= 1'b1;
                r_hold_v <= 1'b0;
                r_busy   <= 1'b0;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_n1_v) begin
            r_hold <= (w_sum[60:56] != 5'd0) ? 16'hFFFF : w_sum[55:40];
        end
        if (r_hold_v && (!r_ov || o_result.ready)) begin
            r_oh <= r_hold;
        end
    end

    assign o_result.valid        = r_ov;
    assign o_result.noise_height = r_oh;

    `FVN_ASSERT(a_one_cell, i_clk, i_rst_n, 1'b1, $onehot0(w_cb), "two octave cells active")
    `FVN_ASSERT(a_hold_busy, i_clk, i_rst_n, r_hold_v, r_busy, "pending result while idle")
    `FVN_ASSERT_NEXT(a_start, i_clk, i_rst_n, w_acc && i_item.mode, r_start_v && r_busy, "query not started")

endmodule

FILE: hdl/fvn_cell.sv
// ----------------------------------------------------------------------------
// Fractal value noise octave cell
// Evaluates one octave: smoothstep weights, four corner reads, bilinear blend,
// amplitude weighting; hands on the doubled point, or the input if disabled.
// ----------------------------------------------------------------------------
module fvn_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [15:0]   i_pers,
    input  fvn_pkg::t_tok i_tok,
    input  logic [7:0]    i_rd_a,
    input  logic [7:0]    i_rd_b,
    output fvn_pkg::t_req o_req,
    output fvn_pkg::t_tok o_tok,
    output logic          o_busy
);
    import fvn_pkg::*;

    localparam logic [2:0] PH_SQR   = 3'd0;
    localparam logic [2:0] PH_SMTH  = 3'd1;
    localparam logic [2:0] PH_ROW0  = 3'd2;
    localparam logic [2:0] PH_ROW1  = 3'd3;
    localparam logic [2:0] PH_BLEND = 3'd4;
    localparam logic [2:0] PH_ACC   = 3'd5;

    logic               r_act;
    logic [2:0]         r_ph;
    logic               r_out_v;
    t_oct               r_cur;
    t_oct               r_out;
    logic [31:0]        r_tx2, r_ty2;
    logic [16:0]        r_sx, r_sy;
    logic [7:0]         r_a, r_b, r_c, r_d;
    logic [23:0]        r_r0, r_r1, r_v;

    logic [GRID_LOG-1:0] w_x0, w_x1, w_y0, w_y1;
    logic [15:0]         w_fx, w_fy;
    logic [49:0]         w_sxp, w_syp;
    logic [16:0]         w_isx, w_isy;
    logic [24:0]         w_row0, w_row1;
    logic [41:0]         w_blend;
    logic [40:0]         w_wv;
    logic [32:0]         w_amp;

    assign w_x0 = r_cur.px[PT_W-1:24];
    assign w_y0 = r_cur.py[PT_W-1:24];
    assign w_x1 = w_x0 + 1'b1;
    assign w_y1 = w_y0 + 1'b1;
    assign w_fx = r_cur.px[23:8];
    assign w_fy = r_cur.py[23:8];

    assign w_sxp   = 50'(r_tx2) * 50'(18'd196608 - {1'b0, w_fx, 1'b0});
    assign w_syp   = 50'(r_ty2) * 50'(18'd196608 - {1'b0, w_fy, 1'b0});
    assign w_isx   = 17'(18'd65536 - 18'(r_sx));
    assign w_isy   = 17'(18'd65536 - 18'(r_sy));
    assign w_row0  = 25'(r_a) * 25'(w_isx) + 25'(r_b) * 25'(r_sx);
    assign w_row1  = 25'(r_c) * 25'(w_isx) + 25'(r_d) * 25'(r_sx);
    assign w_blend = 42'(r_r0) * 42'(w_isy) + 42'(r_r1) * 42'(r_sy);
    assign w_wv    = 41'(r_v) * 41'(r_cur.amp);
    assign w_amp   = 33'(r_cur.amp) * 33'(i_pers);

    always_comb begin
        o_req = '0;
        if (r_act && r_ph == PH_SQR) begin
            o_req.addr_a = {w_y0, w_x0};
            o_req.addr_b = {w_y0, w_x1};
        end else if (r_act && r_ph == PH_SMTH) begin
            o_req.addr_a = {w_y1, w_x0};
            o_req.addr_b = {w_y1, w_x1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_ph    <= PH_SQR;
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            if (i_tok.valid) begin
                if (i_en) begin
                    r_act <= 1'b1;
                    r_ph  <= PH_SQR;
                end else begin
                    r_out_v <= 1'b1;
                end
            end else if (r_act) begin
                if (r_ph == PH_ACC) begin
                    r_act   <= 1'b0;
                    r_out_v <= 1'b1;
                end else begin
                    r_ph <= r_ph + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            r_cur <= i_tok.data;
            if (!i_en) begin
                r_out <= i_tok.data;
            end
        end else if (r_act) begin
            unique case (r_ph)
                PH_SQR: begin
                    r_tx2 <= 32'(w_fx) * 32'(w_fx);
                    r_ty2 <= 32'(w_fy) * 32'(w_fy);
                end
                PH_SMTH: begin
                    r_sx <= w_sxp[48:32];
                    r_sy <= w_syp[48:32];
                    r_a  <= i_rd_a;
                    r_b  <= i_rd_b;
                end
                PH_ROW0: begin
                    r_r0 <= w_row0[23:0];
                    r_c  <= i_rd_a;
                    r_d  <= i_rd_b;
                end
                PH_ROW1: begin
                    r_r1 <= w_row1[23:0];
                end
                PH_BLEND: begin
                    r_v <= w_blend[39:16];
                end
                PH_ACC: begin
                    r_out.px    <= {r_cur.px[PT_W-2:0], 1'b0};
                    r_out.py    <= {r_cur.py[PT_W-2:0], 1'b0};
                    r_out.amp   <= w_amp[32:16];
                    r_out.total <= r_cur.total + TOTAL_W'(w_wv);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_tok.valid = r_out_v;
        o_tok.data  = r_out;
    end

    assign o_busy = r_act;

endmodule
